[hdl/sbpk_pkg.sv]
// ----------------------------------------------------------------------------
// sbpk_pkg
// Shared types, constants and small kernel functions for the sonar beam
// minimum filter and gradient peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sbpk_pkg;

  localparam int MAX_BINS   = 1024;
  localparam int BIN_W      = 10;
  localparam int LINES      = 5;
  localparam int LINE_W     = 3;
  localparam int ADDR_W     = LINE_W + BIN_W;
  localparam int MEM_DEPTH  = LINES * MAX_BINS;
  localparam int WIN        = 5;
  localparam int TAPS       = WIN * WIN;
  localparam int CORDIC_N   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_CLOSEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd2;

  typedef struct packed {
    logic [7:0]         sample;
    logic signed [15:0] beam_bearing;
  } in_t;

  typedef struct packed {
    logic [9:0]         peak_bin;
    logic [7:0]         peak_strength;
    logic signed [15:0] edge_direction;
    logic signed [15:0] peak_bearing;
  } out_t;

  // line that lies back beams behind head, modulo five
  function automatic logic [LINE_W-1:0] line_back(input logic [LINE_W-1:0] head,
                                                  input logic [2:0] back);
    logic [4:0] t;
    t = 5'(head) + 5'd10 - 5'(back);
    if (t >= 5'd10) begin
      t = t - 5'd10;
    end else if (t >= 5'd5) begin
      t = t - 5'd5;
    end
    return t[LINE_W-1:0];
  endfunction

  // gradient across beams; row is bin offset -2 at 0, col is oldest beam at 0
  function automatic logic signed [4:0] phi_w(input logic [2:0] row, input logic [2:0] col);
    logic signed [4:0] m;
    logic signed [4:0] w;
    case (row)
      3'd0, 3'd4: m = 5'sd1;
      3'd1, 3'd3: m = 5'sd4;
      default:    m = 5'sd6;
    endcase
    case (col)
      3'd0:    w = m;
      3'd1:    w = m <<< 1;
      3'd3:    w = -(m <<< 1);
      3'd4:    w = -m;
      default: w = 5'sd0;
    endcase
    return w;
  endfunction

  // gradient across bins
  function automatic logic signed [4:0] dst_w(input logic [2:0] row, input logic [2:0] col);
    logic signed [4:0] m;
    case (col)
      3'd0, 3'd4: m = 5'sd1;
      3'd1, 3'd3: m = 5'sd4;
      default:    m = 5'sd6;
    endcase
    case (row)
      3'd0:    return -m;
      3'd1:    return -(m <<< 1);
      3'd3:    return m <<< 1;
      3'd4:    return m;
      default: return 5'sd0;
    endcase
  endfunction

  function automatic logic [15:0] atan_tab(input logic [3:0] i);
    case (i)
      4'd0:    return 16'd8192;
      4'd1:    return 16'd4836;
      4'd2:    return 16'd2555;
      4'd3:    return 16'd1297;
      4'd4:    return 16'd651;
      4'd5:    return 16'd326;
      4'd6:    return 16'd163;
      4'd7:    return 16'd81;
      4'd8:    return 16'd41;
      4'd9:    return 16'd20;
      4'd10:   return 16'd10;
      4'd11:   return 16'd5;
      4'd12:   return 16'd3;
      4'd13:   return 16'd1;
      4'd14:   return 16'd1;
      default: return 16'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

[hdl/sbpk_cordic.sv]
// ----------------------------------------------------------------------------
// sbpk_cordic
// Iterative vectoring CORDIC: atan2(y, x) as a 16-bit binary angle, one
// micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpk_cordic import sbpk_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [11:0] x_i,
  input  wire logic signed [11:0] y_i,
  output logic                    done_o,
  output logic [15:0]             angle_o
);

  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [3:0]         it_q, it_d;
  logic signed [27:0] x_q, x_d, y_q, y_d;
  logic [15:0]        z_q, z_d;
  logic signed [27:0] xs, ys, x0, y0;

  assign x0 = 28'(x_i) <<< 14;
  assign y0 = 28'(y_i) <<< 14;
  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    it_d   = it_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      run_d = 1'b1;
      it_d  = '0;
      // a negative x is turned by pi first
      if (x_i < 0) begin
        x_d = -x0;
        y_d = -y0;
        z_d = 16'h8000;
      end else begin
        x_d = x0;
        y_d = y0;
        z_d = '0;
      end
    end else if (run_q) begin
      if (y_q > 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_tab(it_q);
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_tab(it_q);
      end
      it_d = it_q + 4'd1;
      if (it_q == 4'(CORDIC_N - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o  = done_q;
  assign angle_o = z_q;

endmodule

`default_nettype wire

[hdl/sonar_beam_min_sobel_peak_detect.sv]
// ----------------------------------------------------------------------------
// sonar_beam_min_sobel_peak_detect
// 5x5 minimum filter over raw beams, then a 5x5 gradient over filtered beams
// with integer magnitude, threshold and CORDIC edge direction.
// ----------------------------------------------------------------------------
//  channel | signals                              | dir | beat
//  --------+--------------------------------------+-----+---------------------
//  in      | in_valid_i, in_ready_o, in_data_i    | in  | one sample of a beam
//  out     | out_valid_o, out_ready_i, out_data_o | out | one peak
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i      | in  | one register write
//
//  one sample at a time, ready only while idle; a sample passes through the
//  minimum (25 reads of the raw store port, a zero write if forced to zero),
//  the gradient, square and root, and the CORDIC on a peak.
//  a finished peak sits in the output register; the next sample is taken
//  while it waits, and only a second peak stalls behind it.
//  no clearing pass: line stores are undefined until written.
`default_nettype none

module sonar_beam_min_sobel_peak_detect import sbpk_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MIN  = 4'd1;
  localparam logic [3:0] ST_SOB  = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_SQA  = 4'd4;
  localparam logic [3:0] ST_SQB  = 4'd5;
  localparam logic [3:0] ST_ROOT = 4'd6;
  localparam logic [3:0] ST_CHK  = 4'd7;
  localparam logic [3:0] ST_CORD = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [9:0]        closest_q;
  logic [10:0]       bins_q;
  logic [7:0]        thr_q;
  logic [BIN_W-1:0]  bin_pos_q, bin_pos_d;
  logic [LINE_W-1:0] head_q, head_d;
  logic [3:0]        seen_q, seen_d;
  logic [15:0]       bear_q [LINES];

  // per-sample context
  logic [BIN_W-1:0]  p_q, p_d;
  logic [10:0]       s_q, s_d;
  logic [15:0]       bin_bear_q, bin_bear_d;
  logic              dmin_q, dmin_d, sob_q, sob_d, nw_q, nw_d, pk_q, pk_d;
  logic [10:0]       c_q, c_d;

  // read sequencer
  logic [2:0]        row_q, row_d, col_q, col_d, rrow_q, rrow_d, rcol_q, rcol_d;
  logic [4:0]        k_q, k_d;
  logic              rv_q, rv_d, rz_q, rz_d;

  logic [7:0]         min_q, min_d, min_new;
  logic signed [16:0] phi_acc_q, phi_acc_d, dst_acc_q, dst_acc_d;
  logic signed [11:0] phi_q, phi_d, dst_q, dst_d;
  logic [22:0]        q_q, q_d;
  logic [7:0]         mag_q, mag_d;
  logic [2:0]         rc_q, rc_d;

  logic [7:0]        raw_mem  [MEM_DEPTH];
  logic [7:0]        filt_mem [MEM_DEPTH];
  logic [7:0]        raw_rd_q, filt_rd_q;
  logic              raw_we, filt_we;
  logic [ADDR_W-1:0] raw_wa, filt_wa, rd_addr;
  logic [7:0]        filt_wd;

  out_t              out_q;
  logic              out_valid_q, out_valid_d, out_load;

  logic              accept;
  logic [10:0]       s_cl;
  logic [BIN_W-1:0]  rd_bin;
  logic signed [12:0] sbin;
  logic              sbin_zero;
  logic [LINE_W-1:0] rd_line;
  logic [7:0]        vz;
  logic signed [13:0] phi_prod, dst_prod;
  logic signed [12:0] mul_a;
  logic signed [25:0] mul_p;
  logic [7:0]        root_t;
  logic signed [16:0] phi_r, dst_r;
  logic              cord_start, cord_done;
  logic [15:0]       cord_ang;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    if (bins_q < 11'd5) begin
      s_cl = 11'd5;
    end else if (bins_q > 11'(MAX_BINS)) begin
      s_cl = 11'(MAX_BINS);
    end else begin
      s_cl = bins_q;
    end
  end

  // read address: raw window in ST_MIN, filtered window in ST_SOB
  assign sbin      = $signed({2'b00, c_q}) - 13'sd2 + $signed({10'd0, row_q});
  assign sbin_zero = (sbin < 0) || (sbin > $signed({2'b00, s_q}) - 13'sd3);
  assign rd_bin    = (state_q == ST_SOB) ? sbin[BIN_W-1:0] :
                     (p_q - 10'd4 + 10'(row_q));
  assign rd_line   = (state_q == ST_SOB) ? line_back(head_q, 3'(nw_q) + 3'd4 - col_q) :
                     line_back(head_q, col_q);
  assign rd_addr   = {rd_line, rd_bin};

  assign raw_we  = accept;
  assign raw_wa  = {head_q, bin_pos_q};
  assign min_new = (rv_q && raw_rd_q < min_q) ? raw_rd_q : min_q;
  assign filt_wa = {head_q, p_q - 10'd2};
  assign filt_wd = dmin_q ? min_new : 8'd0;

  assign vz       = rz_q ? 8'd0 : filt_rd_q;
  assign phi_prod = phi_w(rrow_q, rcol_q) * $signed({1'b0, vz});
  assign dst_prod = dst_w(rrow_q, rcol_q) * $signed({1'b0, vz});

  // one squarer serves both squares and the root search
  assign root_t = mag_q | (8'd1 << rc_q);
  always_comb begin
    case (state_q)
      ST_SQA:  mul_a = 13'(phi_q);
      ST_SQB:  mul_a = 13'(dst_q);
      default: mul_a = $signed({5'd0, root_t});
    endcase
  end
  assign mul_p = mul_a * mul_a;

  // truncation toward zero on divide by 16
  assign phi_r = (phi_acc_q + (phi_acc_q[16] ? 17'sd15 : 17'sd0)) >>> 4;
  assign dst_r = (dst_acc_q + (dst_acc_q[16] ? 17'sd15 : 17'sd0)) >>> 4;

  always_comb begin
    state_d    = state_q;
    bin_pos_d  = bin_pos_q;
    head_d     = head_q;
    seen_d     = seen_q;
    p_d        = p_q;
    s_d        = s_q;
    bin_bear_d = bin_bear_q;
    dmin_d     = dmin_q;
    sob_d      = sob_q;
    nw_d       = nw_q;
    c_d        = c_q;
    pk_d       = pk_q;
    row_d      = row_q;
    col_d      = col_q;
    rrow_d     = rrow_q;
    rcol_d     = rcol_q;
    k_d        = k_q;
    rv_d       = 1'b0;
    rz_d       = rz_q;
    min_d      = min_q;
    phi_acc_d  = phi_acc_q;
    dst_acc_d  = dst_acc_q;
    phi_d      = phi_q;
    dst_d      = dst_q;
    q_d        = q_q;
    mag_d      = mag_q;
    rc_d       = rc_q;
    filt_we    = 1'b0;
    cord_start = 1'b0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          p_d        = bin_pos_q;
          s_d        = s_cl;
          bin_bear_d = in_data_i.beam_bearing;
          dmin_d     = (bin_pos_q >= 10'd4) && (bin_pos_q - 10'd2 >= closest_q);
          pk_d       = 1'b0;
          nw_d       = 1'b0;
          c_d        = 11'(bin_pos_q) - 11'd4;
          sob_d      = 1'b0;
          if (seen_q >= 4'd8 && bin_pos_q >= 10'd4) begin
            sob_d = 1'b1;
          end else if (seen_q >= 4'd9 && bin_pos_q < 10'd2) begin
            sob_d = 1'b1;
            nw_d  = 1'b1;
            c_d   = s_cl - 11'd4 + 11'(bin_pos_q);
          end
          if (c_d < 11'(closest_q) || c_d > s_cl - 11'd3) begin
            sob_d = 1'b0;
          end
          row_d     = '0;
          col_d     = '0;
          k_d       = '0;
          min_d     = 8'hff;
          phi_acc_d = '0;
          dst_acc_d = '0;
          if (seen_q >= 4'd4 && bin_pos_q >= 10'd2 && 11'(bin_pos_q) <= s_cl - 11'd1) begin
            state_d = ST_MIN;
          end else if (sob_d) begin
            state_d = ST_SOB;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MIN, ST_SOB: begin
        if (state_q == ST_MIN && !dmin_q) begin
          filt_we = 1'b1;
          state_d = sob_q ? ST_SOB : ST_DONE;
        end else begin
          if (k_q != 5'(TAPS)) begin
            rv_d   = 1'b1;
            rz_d   = sbin_zero;
            rrow_d = row_q;
            rcol_d = col_q;
            k_d    = k_q + 5'd1;
            if (row_q == 3'(WIN - 1)) begin
              row_d = '0;
              col_d = col_q + 3'd1;
            end else begin
              row_d = row_q + 3'd1;
            end
          end
          if (state_q == ST_MIN) begin
            min_d = min_new;
          end else if (rv_q) begin
            phi_acc_d = phi_acc_q + 17'(phi_prod);
            dst_acc_d = dst_acc_q + 17'(dst_prod);
          end
          if (k_q == 5'(TAPS) && rv_q) begin
            row_d = '0;
            col_d = '0;
            k_d   = '0;
            rv_d  = 1'b0;
            if (state_q == ST_MIN) begin
              filt_we = 1'b1;
              state_d = sob_q ? ST_SOB : ST_DONE;
            end else begin
              state_d = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        phi_d   = phi_r[11:0];
        dst_d   = dst_r[11:0];
        state_d = ST_SQA;
      end
      ST_SQA: begin
        q_d     = mul_p[22:0];
        state_d = ST_SQB;
      end
      ST_SQB: begin
        q_d     = q_q + mul_p[22:0];
        mag_d   = '0;
        rc_d    = 3'd7;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (q_q[22:16] != '0) begin
          mag_d   = 8'hff;
          state_d = ST_CHK;
        end else begin
          if (mul_p[22:0] <= q_q) begin
            mag_d = root_t;
          end
          rc_d = rc_q - 3'd1;
          if (rc_q == 3'd0) begin
            state_d = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (mag_q > thr_q) begin
          cord_start = 1'b1;
          state_d    = ST_CORD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CORD: begin
        if (cord_done) begin
          pk_d    = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!(pk_q && out_valid_q && !out_ready_i)) begin
          out_load = pk_q;
          if (11'(p_q) >= s_q - 11'd1) begin
            bin_pos_d = '0;
            head_d    = (head_q == 3'(LINES - 1)) ? '0 : head_q + 3'd1;
            if (seen_q < 4'd9) begin
              seen_d = seen_q + 4'd1;
            end
          end else begin
            bin_pos_d = p_q + 10'd1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  sbpk_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .x_i     (phi_q),
    .y_i     (dst_q),
    .done_o  (cord_done),
    .angle_o (cord_ang)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      closest_q   <= '0;
      bins_q      <= 11'd1024;
      thr_q       <= 8'd50;
      bin_pos_q   <= '0;
      head_q      <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      bin_pos_q   <= bin_pos_d;
      head_q      <= head_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      rv_q        <= rv_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CLOSEST: closest_q <= cfg_data_i[9:0];
          REG_BINS:    bins_q    <= cfg_data_i;
          REG_THRESH:  thr_q     <= cfg_data_i[7:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    s_q        <= s_d;
    bin_bear_q <= bin_bear_d;
    dmin_q     <= dmin_d;
    sob_q      <= sob_d;
    nw_q       <= nw_d;
    c_q        <= c_d;
    pk_q       <= pk_d;
    row_q      <= row_d;
    col_q      <= col_d;
    rrow_q     <= rrow_d;
    rcol_q     <= rcol_d;
    k_q        <= k_d;
    rz_q       <= rz_d;
    min_q      <= min_d;
    phi_acc_q  <= phi_acc_d;
    dst_acc_q  <= dst_acc_d;
    phi_q      <= phi_d;
    dst_q      <= dst_d;
    q_q        <= q_d;
    mag_q      <= mag_d;
    rc_q       <= rc_d;
    if (out_load) begin
      out_q.peak_bin       <= c_q[9:0];
      out_q.peak_strength  <= mag_q;
      out_q.edge_direction <= cord_ang;
      out_q.peak_bearing   <= bear_q[line_back(head_q, 3'(nw_q) + 3'd4)];
    end
    // bearing is latched after the gradient has read the old entry
    if (state_q == ST_DONE && state_d == ST_IDLE && p_q == '0) begin
      bear_q[head_q] <= bin_bear_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_we) begin
      raw_mem[raw_wa] <= in_data_i.sample;
    end
    raw_rd_q <= raw_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (filt_we) begin
      filt_mem[filt_wa] <= filt_wd;
    end
    filt_rd_q <= filt_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_seen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni) seen_q <= 4'd9)
    else $error("beam count beyond saturation");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < 3'(LINES))
    else $error("line head out of range");
  a_peak_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_data_o.peak_strength > thr_q)
    else $error("peak emitted at or below threshold");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second sample taken before the first finished");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sonar beams sample by sample through the minimum filter and gradient
// peak detector, predicts each peak in lockstep and checks every output beat.
// ----------------------------------------------------------------------------
module testbench;
  import sbpk_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_CLOSEST;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sonar_beam_min_sobel_peak_detect u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  raw_mem [LINES][MAX_BINS];
  logic [7:0]  filt_mem [LINES][MAX_BINS];
  logic [15:0] bearing_mem [LINES];
  int          cur_bin = 0;
  int          beams_done = 0;
  int          head_line = 0;
  int          near_bin = 0;
  int          beam_bins = 1024;
  int          thresh = 50;
  out_t        peaks_due [$];
  in_t         sample_q [$];
  int          errors = 0;
  bit          steady = 1'b0;
  bit          want_hold = 1'b0;
  int          gen_pos = 0;

  int phi_k [5][5] = '{'{1, 2, 0, -2, -1}, '{4, 8, 0, -8, -4}, '{6, 12, 0, -12, -6},
                       '{4, 8, 0, -8, -4}, '{1, 2, 0, -2, -1}};
  int dst_k [5][5] = '{'{-1, -4, -6, -4, -1}, '{-2, -8, -12, -8, -2}, '{0, 0, 0, 0, 0},
                       '{2, 8, 12, 8, 2}, '{1, 4, 6, 4, 1}};
  int atan_k [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

  function automatic int clamped_len();
    if (beam_bins < WIN) return WIN;
    if (beam_bins > MAX_BINS) return MAX_BINS;
    return beam_bins;
  endfunction

  function automatic int back_line(int back);
    return (head_line + 10 - back) % LINES;
  endfunction

  function automatic int filt_rd(int ln, int bin, int s);
    if (bin < 0 || bin > s - 3 || bin >= MAX_BINS) return 0;
    return filt_mem[ln][bin];
  endfunction

  function automatic logic [15:0] edge_angle(int y_in, int x_in);
    longint x, y, xs, ys;
    logic [15:0] z;
    x = longint'(x_in) * 16384;
    y = longint'(y_in) * 16384;
    z = 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 16'd32768;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += 16'(atan_k[i]);
      end else begin
        x -= ys;
        y += xs;
        z -= 16'(atan_k[i]);
      end
    end
    return z;
  endfunction

  function automatic int grad_mag(int a, int b);
    int q, r;
    q = a * a + b * b;
    r = 0;
    if (q >= 65536) return 255;
    while (r < 255 && (r + 1) * (r + 1) <= q) r++;
    return r;
  endfunction

  function automatic void gradient_peak(int newest, int c, int s);
    int   phi, dst, v, ln, m;
    out_t pk;
    phi = 0;
    dst = 0;
    if (c < near_bin || c > s - 3) return;
    for (int col = 0; col < WIN; col++) begin
      ln = back_line(newest + WIN - 1 - col);
      for (int d = -2; d <= 2; d++) begin
        v = filt_rd(ln, c + d, s);
        phi += phi_k[d + 2][col] * v;
        dst += dst_k[d + 2][col] * v;
      end
    end
    phi = phi / 16;
    dst = dst / 16;
    m = grad_mag(phi, dst);
    if (m <= thresh) return;
    pk.peak_bin       = c[9:0];
    pk.peak_strength  = m[7:0];
    pk.edge_direction = edge_angle(dst, phi);
    pk.peak_bearing   = bearing_mem[back_line(newest + 4)];
    peaks_due.insert(peaks_due.size(), pk);
  endfunction

  function automatic void track_sample(in_t it);
    int s, p, b, m, v;
    s = clamped_len();
    p = cur_bin;
    raw_mem[head_line][p] = it.sample;
    if (beams_done >= 4 && p >= 2 && p <= s - 1) begin
      b = p - 2;
      m = 0;
      if (b >= 2 && b >= near_bin) begin
        m = 255;
        for (int back = 0; back < WIN; back++) begin
          for (int d = -2; d <= 2; d++) begin
            v = raw_mem[back_line(back)][b + d];
            if (v < m) m = v;
          end
        end
      end
      filt_mem[head_line][b] = m[7:0];
    end
    if (beams_done >= 8 && p >= 4) begin
      gradient_peak(0, p - 4, s);
    end else if (beams_done >= 9 && p < 2) begin
      gradient_peak(1, s - 4 + p, s);
    end
    if (p == 0) bearing_mem[head_line] = it.beam_bearing;
    if (p >= s - 1) begin
      cur_bin = 0;
      head_line = (head_line + 1) % LINES;
      if (beams_done < 9) beams_done++;
    end else begin
      cur_bin = p + 1;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) track_sample(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (sample_q.size() > 0 && (steady || $urandom_range(0, 99) >= 7)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off once a peak is waiting to back the block up
  int  hold_left = 0;
  bit  hold_used = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (want_hold && !hold_used && out_valid_o) begin
      hold_used   <= 1'b1;
      hold_left   <= 2000;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || $urandom_range(0, 99) >= 7;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (peaks_due.size() == 0) begin
        report_mismatch("unexpected peak bin", out_data_o.peak_bin, -1);
      end else begin
        want = peaks_due.pop_front();
        if (out_data_o.peak_bin !== want.peak_bin)
          report_mismatch("peak_bin", out_data_o.peak_bin, want.peak_bin);
        if (out_data_o.peak_strength !== want.peak_strength)
          report_mismatch("peak_strength", out_data_o.peak_strength, want.peak_strength);
        if (out_data_o.edge_direction !== want.edge_direction)
          report_mismatch("edge_direction", out_data_o.edge_direction, want.edge_direction);
        if (out_data_o.peak_bearing !== want.peak_bearing)
          report_mismatch("peak_bearing", out_data_o.peak_bearing, want.peak_bearing);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_CLOSEST: near_bin = val & 'h3ff;
      REG_BINS:    beam_bins = val & 'h7ff;
      default:     thresh = val & 'hff;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || peaks_due.size() != 0);
    repeat (150) @(posedge clk_i);
  endtask

  // beams built from flat blocks, steps and random noise so the gradient finds edges
  task automatic make_beams(int count);
    int s, pat, lvl_a, lvl_b, split;
    in_t it;
    s = clamped_len();
    pat = 0; lvl_a = 0; lvl_b = 0; split = 0;
    repeat (count) begin
      if (gen_pos == 0) begin
        pat   = $urandom_range(0, 3);
        lvl_a = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 255);
        lvl_b = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255);
        split = $urandom_range(0, s);
      end
      case (pat)
        0:       it.sample = 8'($urandom_range(0, 255));
        1:       it.sample = 8'(lvl_a);
        2:       it.sample = 8'((gen_pos < split) ? lvl_a : lvl_b);
        default: it.sample = 8'(lvl_b + $urandom_range(0, 15));
      endcase
      if ($urandom_range(0, 99) < 7) it.sample = 8'($urandom_range(0, 255));
      it.beam_bearing = 16'($urandom);
      sample_q.insert(sample_q.size(), it);
      gen_pos = (gen_pos >= s - 1) ? 0 : gen_pos + 1;
    end
  endtask

  initial begin
    in_t it;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // oversize length clamps to the full beam; bins only ever shrink from here
    write_reg(REG_BINS, 2047);
    make_beams(50);
    drain();
    write_reg(REG_BINS, 40);
    write_reg(REG_THRESH, 0);
    write_reg(REG_CLOSEST, 0);
    gen_pos = 0;
    for (int i = 0; i < 20; i++) begin
      it.sample       = (i % 2) ? 8'd255 : 8'd0;
      it.beam_bearing = (i % 3 == 0) ? 16'sh8000 : ((i % 3 == 1) ? 16'sh7fff : 16'sh0000);
      sample_q.insert(sample_q.size(), it);
      gen_pos = (gen_pos >= 39) ? 0 : gen_pos + 1;
    end
    make_beams(420);
    want_hold = 1'b1;
    make_beams(200);
    drain();
    write_reg(REG_CLOSEST, 1023);
    write_reg(REG_THRESH, 255);
    make_beams(60);
    drain();
    write_reg(REG_CLOSEST, $urandom_range(0, 20));
    write_reg(REG_THRESH, $urandom_range(0, 80));
    write_reg(REG_BINS, 24);
    steady = 1'b1;
    make_beams(200);
    drain();
    steady = 1'b0;
    make_beams(220);
    drain();
    write_reg(REG_CLOSEST, 3);
    write_reg(REG_THRESH, 20);
    write_reg(REG_BINS, 12);
    make_beams(200);
    drain();
    write_reg(REG_CLOSEST, 0);
    write_reg(REG_BINS, 5);
    make_beams(100);
    drain();
    // below the window size clamps to five
    write_reg(REG_BINS, 0);
    write_reg(REG_THRESH, 5);
    make_beams(100);
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
